// ===== hw/rtl/cop_pkg.sv =====
package cop_pkg;

  // default geometry
  localparam int unsigned COORD_BITS_DEF  = 9;
  localparam int unsigned RADIUS_BITS_DEF = 8;
  localparam int unsigned COLOR_BITS      = 16;

  // run descriptor queue
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // decision variable constants
  localparam int DEC_INIT     = 3;
  localparam int DEC_STEP_NEG = 6;
  localparam int DEC_STEP_POS = 10;

  // points per run
  localparam int unsigned NUM_POINTS = 8;
  localparam int unsigned PT_IDX_W   = $clog2(NUM_POINTS);

  typedef logic [PT_IDX_W-1:0] pt_idx_t;

  localparam pt_idx_t LAST_IDX = pt_idx_t'(NUM_POINTS - 1);

  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_e;

  // how one mirrored point is formed from (a, b)
  typedef struct packed {
    logic x_is_a;  // x offset uses a, y offset uses b
    logic x_neg;
    logic y_neg;
  } octant_t;

  function automatic octant_t octant_sel(pt_idx_t idx);
    octant_t sel;
    case (idx)
      pt_idx_t'(0): sel = '{x_is_a: 1'b0, x_neg: 1'b1, y_neg: 1'b1};
      pt_idx_t'(1): sel = '{x_is_a: 1'b0, x_neg: 1'b0, y_neg: 1'b1};
      pt_idx_t'(2): sel = '{x_is_a: 1'b1, x_neg: 1'b1, y_neg: 1'b0};
      pt_idx_t'(3): sel = '{x_is_a: 1'b1, x_neg: 1'b1, y_neg: 1'b1};
      pt_idx_t'(4): sel = '{x_is_a: 1'b0, x_neg: 1'b0, y_neg: 1'b0};
      pt_idx_t'(5): sel = '{x_is_a: 1'b1, x_neg: 1'b0, y_neg: 1'b1};
      pt_idx_t'(6): sel = '{x_is_a: 1'b1, x_neg: 1'b0, y_neg: 1'b0};
      default:      sel = '{x_is_a: 1'b0, x_neg: 1'b1, y_neg: 1'b0};
    endcase
    return sel;
  endfunction

endpackage

// ===== hw/rtl/cop_front.sv =====
module cop_front import cop_pkg::*; #(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic [COORD_BITS-1:0]  center_x_i,
  input  logic [COORD_BITS-1:0]  center_y_i,
  input  logic [RADIUS_BITS-1:0] radius_i,
  input  logic [COLOR_BITS-1:0]  pixel_color_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output logic [COORD_BITS-1:0]  run_cx_o,
  output logic [COORD_BITS-1:0]  run_cy_o,
  output logic [RADIUS_BITS:0]   run_a_o,
  output logic [RADIUS_BITS:0]   run_b_o,
  output logic [COLOR_BITS-1:0]  run_color_o,
  output logic                   run_done_o
);

  localparam int unsigned STEP_BITS = RADIUS_BITS + 1;
  localparam int unsigned DEC_BITS  = RADIUS_BITS + 4;

  logic [COORD_BITS-1:0] ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d;
  logic [STEP_BITS-1:0]  step_a_q, step_a_d, step_b_q, step_b_d;
  logic [DEC_BITS-1:0]   decision_q, decision_d;
  logic [COLOR_BITS-1:0] held_color_q, held_color_d;
  logic                  drawing_q, drawing_d;

  logic                  is_start, emit, fire, dec_b;
  logic [COORD_BITS-1:0] cur_cx, cur_cy;
  logic [STEP_BITS-1:0]  cur_a, cur_b, nb;
  logic [STEP_BITS:0]    na;
  logic [DEC_BITS-1:0]   cur_d, d_next;
  logic [COLOR_BITS-1:0] cur_color;
  logic                  done;

  assign is_start = (op_e'(operation_i) == OP_START);
  assign emit     = is_start || drawing_q;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && emit;
  assign fire     = in_valid_i && in_ready_o && emit;

  // working values: freshly loaded on start, else the walker state
  always_comb begin
    if (is_start) begin
      cur_cx    = center_x_i;
      cur_cy    = center_y_i;
      cur_a     = '0;
      cur_b     = STEP_BITS'(radius_i);
      cur_d     = DEC_BITS'(DEC_INIT) - (DEC_BITS'(radius_i) << 1);
      cur_color = pixel_color_i;
    end else begin
      cur_cx    = ctr_x_q;
      cur_cy    = ctr_y_q;
      cur_a     = step_a_q;
      cur_b     = step_b_q;
      cur_d     = decision_q;
      cur_color = held_color_q;
    end
  end

  // walker advance
  always_comb begin
    na    = (STEP_BITS+1)'(cur_a) + (STEP_BITS+1)'(1);
    dec_b = !cur_d[DEC_BITS-1];
    if (dec_b) begin
      d_next = cur_d + ((DEC_BITS'(na) - DEC_BITS'(cur_b)) << 2) + DEC_BITS'(DEC_STEP_POS);
      nb     = cur_b - STEP_BITS'(1);
      done   = ((STEP_BITS+1)'(cur_b) <= na);
    end else begin
      d_next = cur_d + (DEC_BITS'(na) << 2) + DEC_BITS'(DEC_STEP_NEG);
      nb     = cur_b;
      done   = ((STEP_BITS+1)'(cur_b) < na);
    end
  end

  assign run_cx_o    = cur_cx;
  assign run_cy_o    = cur_cy;
  assign run_a_o     = cur_a;
  assign run_b_o     = cur_b;
  assign run_color_o = cur_color;
  assign run_done_o  = done;

  always_comb begin
    ctr_x_d      = ctr_x_q;
    ctr_y_d      = ctr_y_q;
    step_a_d     = step_a_q;
    step_b_d     = step_b_q;
    decision_d   = decision_q;
    held_color_d = held_color_q;
    drawing_d    = drawing_q;
    if (fire) begin
      ctr_x_d      = cur_cx;
      ctr_y_d      = cur_cy;
      step_a_d     = na[STEP_BITS-1:0];
      step_b_d     = nb;
      decision_d   = d_next;
      held_color_d = cur_color;
      drawing_d    = !done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q      <= '0;
      ctr_y_q      <= '0;
      step_a_q     <= '0;
      step_b_q     <= '0;
      decision_q   <= '0;
      held_color_q <= '0;
      drawing_q    <= 1'b0;
    end else begin
      ctr_x_q      <= ctr_x_d;
      ctr_y_q      <= ctr_y_d;
      step_a_q     <= step_a_d;
      step_b_q     <= step_b_d;
      decision_q   <= decision_d;
      held_color_q <= held_color_d;
      drawing_q    <= drawing_d;
    end
  end

endmodule

// ===== hw/rtl/cop_queue.sv =====
module cop_queue import cop_pkg::*; #(
  parameter int unsigned DATA_W = 1,
  parameter int unsigned DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/cop_back.sv =====
module cop_back import cop_pkg::*; #(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  logic [COORD_BITS-1:0]        run_cx_i,
  input  logic [COORD_BITS-1:0]        run_cy_i,
  input  logic [RADIUS_BITS:0]         run_a_i,
  input  logic [RADIUS_BITS:0]         run_b_i,
  input  logic [COLOR_BITS-1:0]        run_color_i,
  input  logic                         run_done_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS+1:0] point_x_o,
  output logic signed [COORD_BITS+1:0] point_y_o,
  output logic [COLOR_BITS-1:0]        point_color_o,
  output logic                         run_last_o,
  output logic                         circle_done_o
);

  localparam int unsigned POINT_BITS = COORD_BITS + 2;
  localparam int unsigned STEP_BITS  = RADIUS_BITS + 1;

  logic                  out_valid_q, out_valid_d;
  logic [POINT_BITS-1:0] px_q, py_q, px_d, py_d;
  logic [COLOR_BITS-1:0] color_q;
  logic                  last_q, done_q;
  pt_idx_t               idx_q, idx_d;
  octant_t               sel;
  logic [STEP_BITS-1:0]  mag_x, mag_y;
  logic                  load;

  assign load        = pop_valid_i && (!out_valid_q || out_ready_i);
  assign pop_ready_o = load && (idx_q == LAST_IDX);

  always_comb begin
    sel   = octant_sel(idx_q);
    mag_x = sel.x_is_a ? run_a_i : run_b_i;
    mag_y = sel.x_is_a ? run_b_i : run_a_i;
    px_d  = sel.x_neg ? POINT_BITS'(run_cx_i) - POINT_BITS'(mag_x)
                      : POINT_BITS'(run_cx_i) + POINT_BITS'(mag_x);
    py_d  = sel.y_neg ? POINT_BITS'(run_cy_i) - POINT_BITS'(mag_y)
                      : POINT_BITS'(run_cy_i) + POINT_BITS'(mag_y);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + pt_idx_t'(1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q    <= px_d;
      py_q    <= py_d;
      color_q <= run_color_i;
      last_q  <= (idx_q == LAST_IDX);
      done_q  <= run_done_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;
  assign point_color_o = color_q;
  assign run_last_o    = last_q;
  assign circle_done_o = done_q;

endmodule

// ===== hw/rtl/circle_octant_point_generator_unit.sv =====
// Midpoint circle point generator. A start transaction (operation 0) loads center, radius
// and color; each start, and each next transaction (operation 1) while a circle is active,
// yields eight mirrored points of the current octant step, the eighth flagged run_last,
// all eight flagged circle_done on the run that finishes the circle. A next transaction
// with no active circle yields nothing. Points are offsets from the center, order:
// (-b,-a) (+b,-a) (-a,+b) (-a,-b) (+b,+a) (+a,-b) (+a,+b) (-b,+a), wrapped to the signed
// output width. Throughput: one point per cycle on the output while a run is queued and
// out_ready_i is high, set by the single output register of the point emitter; a next
// transaction with nothing to emit pushes no run. The input side accepts a transaction
// in any cycle in which the two-entry run queue between walker and emitter has room.
module circle_octant_point_generator_unit import cop_pkg::*; #(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input transactions
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic [COORD_BITS-1:0]        center_x_i,
  input  logic [COORD_BITS-1:0]        center_y_i,
  input  logic [RADIUS_BITS-1:0]       radius_i,
  input  logic [COLOR_BITS-1:0]        pixel_color_i,
  // point transactions
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS+1:0] point_x_o,
  output logic signed [COORD_BITS+1:0] point_y_o,
  output logic [COLOR_BITS-1:0]        point_color_o,
  output logic                         run_last_o,
  output logic                         circle_done_o
);

  localparam int unsigned STEP_BITS = RADIUS_BITS + 1;
  // run descriptor: center, a, b, color, done
  localparam int unsigned DESC_W    = 2 * COORD_BITS + 2 * STEP_BITS + COLOR_BITS + 1;

  // walker side of the queue
  logic                  push_valid, push_ready;
  logic [COORD_BITS-1:0] f_cx, f_cy;
  logic [STEP_BITS-1:0]  f_a, f_b;
  logic [COLOR_BITS-1:0] f_color;
  logic                  f_done;
  logic [DESC_W-1:0]     push_data;

  // emitter side of the queue
  logic                  pop_valid, pop_ready;
  logic [DESC_W-1:0]     pop_data;
  logic [COORD_BITS-1:0] b_cx, b_cy;
  logic [STEP_BITS-1:0]  b_a, b_b;
  logic [COLOR_BITS-1:0] b_color;
  logic                  b_done;

  // front: takes transactions, keeps the walker state, forms one run per point step
  cop_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .pixel_color_i (pixel_color_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .run_cx_o      (f_cx),
    .run_cy_o      (f_cy),
    .run_a_o       (f_a),
    .run_b_o       (f_b),
    .run_color_o   (f_color),
    .run_done_o    (f_done)
  );

  assign push_data = {f_cx, f_cy, f_a, f_b, f_color, f_done};

  // short queue of pending runs so the walker runs ahead of the emitter
  cop_queue #(
    .DATA_W (DESC_W),
    .DEPTH  (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {b_cx, b_cy, b_a, b_b, b_color, b_done} = pop_data;

  // back: emits the eight mirrored points of the head run, one per cycle while out_ready_i is high
  cop_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .run_cx_i      (b_cx),
    .run_cy_i      (b_cy),
    .run_a_i       (b_a),
    .run_b_i       (b_b),
    .run_color_i   (b_color),
    .run_done_i    (b_done),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_color_o (point_color_o),
    .run_last_o    (run_last_o),
    .circle_done_o (circle_done_o)
  );

endmodule
